// ===== design/gscp_pkg.sv =====
package gscp_pkg;

	localparam int MAX_CANDIDATES_DEF = 4096;
	localparam int VECTOR_WORDS_DEF   = 7;
	localparam int PATTERN_BITS_DEF   = 7;

	localparam int WORD_W    = 64;
	localparam int ID_MASK_W = 30;
	localparam int GAIN_W    = 9;

	typedef enum logic [1:0] {
		REQ_LOAD_CAND = 2'd0,
		REQ_LOAD_UNC  = 2'd1,
		REQ_PICK      = 2'd2,
		REQ_NONE      = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_PICKED = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_STUCK  = 2'd2
	} pick_status_t;

	typedef enum logic [0:0] {
		CFG_SCENARIO = 1'd0,
		CFG_COUNT    = 1'd1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_DRAIN,
		FSM_CLEAR_RD,
		FSM_CLEAR_WB,
		FSM_RESULT
	} fsm_t;

	typedef struct packed {
		logic start;
		logic issue;
	} scan_ctl_t;

endpackage

// ===== design/gscp_store.sv =====
module gscp_store #(
	parameter int MAX_CANDIDATES = gscp_pkg::MAX_CANDIDATES_DEF,
	parameter int VECTOR_WORDS   = gscp_pkg::VECTOR_WORDS_DEF,
	parameter int PATTERN_BITS   = gscp_pkg::PATTERN_BITS_DEF,
	localparam int AW = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1,
	localparam int WW = (VECTOR_WORDS > 1) ? $clog2(VECTOR_WORDS) : 1
) (
	input  logic                            clk,
	input  logic                            wr_en,
	input  logic [AW-1:0]                   wr_addr,
	input  logic [WW-1:0]                   wr_word,
	input  logic [gscp_pkg::WORD_W-1:0]     wr_value,
	input  logic [gscp_pkg::ID_MASK_W-1:0]  wr_mask,
	input  logic [PATTERN_BITS-1:0]         wr_pat,
	input  logic                            rd_en,
	input  logic [AW-1:0]                   rd_addr,
	output logic [gscp_pkg::WORD_W-1:0]     rd_row [VECTOR_WORDS],
	output logic [gscp_pkg::ID_MASK_W-1:0]  rd_mask,
	output logic [PATTERN_BITS-1:0]         rd_pat
);

	logic [gscp_pkg::WORD_W-1:0]    cov_mem  [MAX_CANDIDATES][VECTOR_WORDS];
	logic [gscp_pkg::ID_MASK_W-1:0] mask_mem [MAX_CANDIDATES];
	logic [PATTERN_BITS-1:0]        pat_mem  [MAX_CANDIDATES];

	// One word of a row is written per load; the mask and pattern go with it.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			cov_mem[wr_addr][wr_word] <= wr_value;
			mask_mem[wr_addr]         <= wr_mask;
			pat_mem[wr_addr]          <= wr_pat;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_row  <= cov_mem[rd_addr];
			rd_mask <= mask_mem[rd_addr];
			rd_pat  <= pat_mem[rd_addr];
		end
	end

endmodule

// ===== design/gscp_scan.sv =====
module gscp_scan #(
	parameter int MAX_CANDIDATES = gscp_pkg::MAX_CANDIDATES_DEF,
	parameter int VECTOR_WORDS   = gscp_pkg::VECTOR_WORDS_DEF,
	parameter int PATTERN_BITS   = gscp_pkg::PATTERN_BITS_DEF,
	localparam int AW = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1,
	localparam int GW = $clog2(VECTOR_WORDS * gscp_pkg::WORD_W + 1),
	localparam int PW = $clog2(gscp_pkg::WORD_W + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  gscp_pkg::scan_ctl_t             ctl,
	input  logic [AW-1:0]                   addr,
	input  logic [gscp_pkg::WORD_W-1:0]     uncov [VECTOR_WORDS],
	input  logic [PATTERN_BITS-1:0]         scen,
	input  logic [gscp_pkg::WORD_W-1:0]     rd_row [VECTOR_WORDS],
	input  logic [gscp_pkg::ID_MASK_W-1:0]  rd_mask,
	input  logic [PATTERN_BITS-1:0]         rd_pat,
	output logic [GW-1:0]                   lead_gain,
	output logic [gscp_pkg::ID_MASK_W-1:0]  lead_mask,
	output logic [AW-1:0]                   lead_slot,
	output logic                            busy
);

	logic                           valid_s1, valid_s2;
	logic [AW-1:0]                  idx_s1, idx_s2;
	logic [PW-1:0]                  cnt_s2 [VECTOR_WORDS];
	logic                           qual_s2;
	logic [gscp_pkg::ID_MASK_W-1:0] mask_s2;
	logic [GW-1:0]                  gain;
	logic                           better;
	logic [GW-1:0]                  lead_gain_q;
	logic [gscp_pkg::ID_MASK_W-1:0] lead_mask_q;
	logic [AW-1:0]                  lead_slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= ctl.issue;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= addr;
		idx_s2  <= idx_s1;
		mask_s2 <= rd_mask;
		qual_s2 <= (rd_pat != '0) && ((rd_pat & scen) == scen);
		for (int w = 0; w < VECTOR_WORDS; w++)
			cnt_s2[w] <= PW'($countones(rd_row[w] & uncov[w]));
	end

	always_comb begin
		gain = '0;
		for (int w = 0; w < VECTOR_WORDS; w++)
			gain = gain + GW'(cnt_s2[w]);
	end

	// An equal nonzero gain is taken when the held mask is zero or the new mask is smaller.
	assign better = qual_s2 && ((gain > lead_gain_q) ||
		((gain == lead_gain_q) && (gain != '0) &&
		 ((lead_mask_q == '0) || (mask_s2 < lead_mask_q))));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_gain_q <= '0;
			lead_mask_q <= '0;
			lead_slot_q <= '0;
		end else if (ctl.start) begin
			lead_gain_q <= '0;
			lead_mask_q <= '0;
			lead_slot_q <= '0;
		end else if (valid_s2 && better) begin
			lead_gain_q <= gain;
			lead_mask_q <= mask_s2;
			lead_slot_q <= idx_s2;
		end
	end

	assign lead_gain = lead_gain_q;
	assign lead_mask = lead_mask_q;
	assign lead_slot = lead_slot_q;
	assign busy      = valid_s1 || valid_s2;

	a_gain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (32'(gain) <= VECTOR_WORDS * gscp_pkg::WORD_W))
		else $error("gain exceeds vector width");
	a_best_mono: assert property (@(posedge clk) disable iff (!arst_n)
		!ctl.start && !$past(ctl.start) |-> lead_gain_q >= $past(lead_gain_q))
		else $error("leading gain decreased during a scan");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> !busy)
		else $error("scan started with words in flight");

endmodule

// ===== design/greedy_set_cover_picker_top.sv =====
// Channel  Direction  Handshake                 Payload
// s_       in         s_tvalid / s_tready       s_tdata, s_tuser (request kind)
// m_       out        m_tvalid / m_tready       m_tdata, m_tuser (pick status)
// cfg_     in         cfg_valid / cfg_ready     cfg_index, cfg_data
// A pick scans up to min(cand_count, MAX_CANDIDATES) candidate rows:
// the scan reads one whole candidate row per cycle from the coverage memory's single
// read port, then the chosen row is read once more to clear its bits from the uncovered set.
// Reset clears the control state and the uncovered set; the candidate memories are not cleared.
// A new word is taken while the last result still waits; a finished pick waits for the
// output register to be free.
module greedy_set_cover_picker_top #(
	parameter int MAX_CANDIDATES = gscp_pkg::MAX_CANDIDATES_DEF,
	parameter int VECTOR_WORDS   = gscp_pkg::VECTOR_WORDS_DEF,
	parameter int PATTERN_BITS   = gscp_pkg::PATTERN_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [11:0] cand_index, [14:12] word_index, [78:15] word_value,
	// [108:79] cand_id_mask, [115:109] cand_pattern, [119:116] zero
	input  logic [119:0] s_tdata,
	// [1:0] req_type
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [29:0] picked_mask, [38:30] picked_gain, [39] cover_done
	output logic [39:0]  m_tdata,
	// [1:0] pick_status
	output logic [1:0]   m_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [0:0]   cfg_index,
	input  logic [12:0]  cfg_data
);

	localparam int AW = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
	localparam int WW = (VECTOR_WORDS > 1) ? $clog2(VECTOR_WORDS) : 1;
	localparam int CW = $clog2(MAX_CANDIDATES + 1);
	localparam int GW = $clog2(VECTOR_WORDS * gscp_pkg::WORD_W + 1);
	localparam int WORD_W = gscp_pkg::WORD_W;

	logic [11:0]                    in_cand;
	logic [2:0]                     in_word;
	logic [WORD_W-1:0]              in_value;
	logic [gscp_pkg::ID_MASK_W-1:0] in_mask;
	logic [6:0]                     in_pat;
	gscp_pkg::req_t                 in_req;
	logic [3:0]                     word4;
	logic [15:0]                    pat16, scen16;
	logic                           word_ok, slot_ok, accept;

	gscp_pkg::fsm_t                 state_q, state_d;
	logic [CW-1:0]                  cnt_q, limit_q, limit_d;
	logic [6:0]                     scen_q;
	logic [12:0]                    count_q;
	logic [WORD_W-1:0]              uncov_q [VECTOR_WORDS];
	logic                           uncov_empty;
	gscp_pkg::pick_status_t         status_q;
	logic                           out_valid_q;
	logic [39:0]                    out_data_q;
	gscp_pkg::pick_status_t         out_status_q;

	gscp_pkg::scan_ctl_t            ctl;
	logic                           rd_en;
	logic [AW-1:0]                  rd_addr;
	logic [WORD_W-1:0]              rd_row [VECTOR_WORDS];
	logic [gscp_pkg::ID_MASK_W-1:0] rd_mask;
	logic [PATTERN_BITS-1:0]        rd_pat;
	logic [GW-1:0]                  lead_gain;
	logic [gscp_pkg::ID_MASK_W-1:0] lead_mask;
	logic [AW-1:0]                  lead_slot;
	logic                           busy;
	logic [31:0]                    gain32;
	logic                           out_free;

	assign in_cand  = s_tdata[11:0];
	assign in_word  = s_tdata[14:12];
	assign in_value = s_tdata[78:15];
	assign in_mask  = s_tdata[108:79];
	assign in_pat   = s_tdata[115:109];
	assign in_req   = gscp_pkg::req_t'(s_tuser);
	assign word4    = 4'(in_word);
	assign pat16    = 16'(in_pat);
	assign scen16   = 16'(scen_q);
	assign word_ok  = 32'(in_word) < VECTOR_WORDS;
	assign slot_ok  = 32'(in_cand) < MAX_CANDIDATES;

	assign s_tready  = (state_q == gscp_pkg::FSM_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || m_tready;

	assign limit_d = (32'(count_q) > MAX_CANDIDATES) ? CW'(MAX_CANDIDATES) : CW'(32'(count_q));

	always_comb begin
		uncov_empty = 1'b1;
		for (int w = 0; w < VECTOR_WORDS; w++)
			if (uncov_q[w] != '0) uncov_empty = 1'b0;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gscp_pkg::FSM_IDLE: begin
				if (accept && in_req == gscp_pkg::REQ_PICK) begin
					if (uncov_empty)       state_d = gscp_pkg::FSM_RESULT;
					else if (limit_d == '0) state_d = gscp_pkg::FSM_DRAIN;
					else                   state_d = gscp_pkg::FSM_SCAN;
				end
			end
			gscp_pkg::FSM_SCAN:
				if (cnt_q == limit_q - CW'(1)) state_d = gscp_pkg::FSM_DRAIN;
			gscp_pkg::FSM_DRAIN:
				if (!busy) state_d = (lead_gain != '0) ? gscp_pkg::FSM_CLEAR_RD
				                                        : gscp_pkg::FSM_RESULT;
			gscp_pkg::FSM_CLEAR_RD: state_d = gscp_pkg::FSM_CLEAR_WB;
			gscp_pkg::FSM_CLEAR_WB: state_d = gscp_pkg::FSM_RESULT;
			gscp_pkg::FSM_RESULT:
				if (out_free) state_d = gscp_pkg::FSM_IDLE;
			default: state_d = gscp_pkg::FSM_IDLE;
		endcase
	end

	always_comb begin
		ctl.start = 1'b0;
		ctl.issue = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = cnt_q[AW-1:0];
		unique case (state_q)
			gscp_pkg::FSM_IDLE: ctl.start = accept && (in_req == gscp_pkg::REQ_PICK);
			gscp_pkg::FSM_SCAN: begin
				ctl.issue = 1'b1;
				rd_en     = 1'b1;
			end
			gscp_pkg::FSM_CLEAR_RD: begin
				rd_en   = 1'b1;
				rd_addr = lead_slot;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scen_q  <= 7'd127;
			count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (gscp_pkg::cfg_reg_t'(cfg_index))
				gscp_pkg::CFG_SCENARIO: scen_q  <= cfg_data[6:0];
				gscp_pkg::CFG_COUNT:    count_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= gscp_pkg::FSM_IDLE;
			cnt_q    <= '0;
			limit_q  <= '0;
			status_q <= gscp_pkg::ST_PICKED;
			for (int w = 0; w < VECTOR_WORDS; w++)
				uncov_q[w] <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == gscp_pkg::FSM_IDLE && accept) begin
				cnt_q   <= '0;
				limit_q <= limit_d;
				status_q <= uncov_empty ? gscp_pkg::ST_EMPTY : gscp_pkg::ST_STUCK;
				if (in_req == gscp_pkg::REQ_LOAD_UNC && word_ok)
					uncov_q[word4[WW-1:0]] <= in_value;
			end
			if (state_q == gscp_pkg::FSM_SCAN)
				cnt_q <= cnt_q + CW'(1);
			if (state_q == gscp_pkg::FSM_CLEAR_WB) begin
				status_q <= gscp_pkg::ST_PICKED;
				for (int w = 0; w < VECTOR_WORDS; w++)
					uncov_q[w] <= uncov_q[w] & ~rd_row[w];
			end
		end
	end

	assign gain32 = 32'(lead_gain);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == gscp_pkg::FSM_RESULT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == gscp_pkg::FSM_RESULT && out_free) begin
			out_status_q <= status_q;
			if (status_q == gscp_pkg::ST_PICKED)
				out_data_q <= {uncov_empty, gain32[8:0], lead_mask};
			else
				out_data_q <= {(status_q == gscp_pkg::ST_EMPTY), 39'd0};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_status_q;

	gscp_store #(
		.MAX_CANDIDATES(MAX_CANDIDATES),
		.VECTOR_WORDS  (VECTOR_WORDS),
		.PATTERN_BITS  (PATTERN_BITS)
	) u_store (
		.clk     (clk),
		.wr_en   (accept && in_req == gscp_pkg::REQ_LOAD_CAND && word_ok && slot_ok),
		.wr_addr (AW'(32'(in_cand))),
		.wr_word (word4[WW-1:0]),
		.wr_value(in_value),
		.wr_mask (in_mask),
		.wr_pat  (pat16[PATTERN_BITS-1:0]),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_row  (rd_row),
		.rd_mask (rd_mask),
		.rd_pat  (rd_pat)
	);

	gscp_scan #(
		.MAX_CANDIDATES(MAX_CANDIDATES),
		.VECTOR_WORDS  (VECTOR_WORDS),
		.PATTERN_BITS  (PATTERN_BITS)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.addr     (cnt_q[AW-1:0]),
		.uncov    (uncov_q),
		.scen     (scen16[PATTERN_BITS-1:0]),
		.rd_row   (rd_row),
		.rd_mask  (rd_mask),
		.rd_pat   (rd_pat),
		.lead_gain(lead_gain),
		.lead_mask(lead_mask),
		.lead_slot(lead_slot),
		.busy     (busy)
	);

	a_empty_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == gscp_pkg::ST_EMPTY |-> m_tdata[39])
		else $error("empty result without cover_done");
	a_stuck_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == gscp_pkg::ST_STUCK |-> m_tdata == '0)
		else $error("stuck result carries a pick");
	a_rise_from_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == gscp_pkg::FSM_RESULT)
		else $error("result appeared outside the result state");
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gscp_pkg::FSM_SCAN |-> cnt_q < limit_q)
		else $error("scan ran past the candidate count");

endmodule
